// ===== hdl/erj_pkg.sv =====
// Package: shared types, constants and fixed-point helpers for the epipolar block.
package erj_pkg;

    localparam int RES_FRAC = 24;

    typedef logic signed [31:0] word_t;
    typedef word_t vec3_t [3];
    typedef word_t mat3_t [3][3];

    // Clamp a wide sum to the signed 32-bit range.
    function automatic word_t sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -67'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Product of two Q7.24 words, rounded half up back to 24 fraction bits.
    function automatic logic signed [40:0] mulq(input word_t a, input word_t b);
        logic signed [63:0] p;
        logic signed [64:0] s;
        p = a * b;
        s = {p[63], p} + 65'sd8388608;
        return s[64:24];
    endfunction

endpackage

// ===== hdl/epipolar_residual_jacobian.sv =====
// Top level: pipelined epipolar residual and Jacobian unit.
//
// Usage: one transaction on the s_axis side carries both quaternions and both
// bearing vectors; each yields exactly one m_axis transaction with the
// residual and five Jacobian entries, all signed Q7.24 saturated.
// Pipeline: six register stages; m_axis_tvalid rises once the accepted
// transaction reaches the stage 6 output register.
//   stage 1 rotation matrices, stage 2 R*p2 and p1 x t, stage 3 t x v,
//   (p1xt)^T R and v x p1, stage 4 rotation Jacobian cross and the three
//   dot-product terms, stage 5 the final sums, stage 6 output register.
// Throughput: one transaction per cycle while the output is not stalled; the
// six-stage register chain with a single advance enable sets this figure.
// Stall: when m_axis_tready is low and the output holds valid data the
// whole pipeline freezes; s_axis_tready falls only then, so nothing is lost
// or repeated. Bubbles are not squeezed out: all stages advance together,
// so an empty slot travels along with the data around it.
// Reset: rst_n clears all valid bits; data registers are not reset.
module epipolar_residual_jacobian #(
    parameter int FRAC_BITS = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // rot_qx, rot_qy, rot_qz, rot_qw, dir_qx, dir_qy, dir_qz, dir_qw,
    // first_bearing, second_bearing (lowest bits first)
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // residual, jac_rot_x, jac_rot_y, jac_rot_z, jac_dir_a, jac_dir_b
    output logic [191:0] m_axis_tdata
);
    import erj_pkg::*;

    localparam int NST = 6;
    localparam int SH = RES_FRAC - FRAC_BITS;

    logic [NST-1:0] vld_reg;
    logic           adv;

    // Advance the whole chain unless the output holds a result not taken.
    assign adv = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    // Stage 1: rotation matrices; bearing vectors scaled to 24 fraction bits.
    mat3_t r1, rt1;
    vec3_t p1_1_reg, p2_1_reg;
    vec3_t p1_in, p2_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_in[i] = word_t'(signed'(s_axis_tdata[128+16*i +: 16])) <<< SH;
            p2_in[i] = word_t'(signed'(s_axis_tdata[176+16*i +: 16])) <<< SH;
        end
    end

    erj_quat u_rq (.clk(clk), .en(adv),
        .qx(s_axis_tdata[15:0]), .qy(s_axis_tdata[31:16]),
        .qz(s_axis_tdata[47:32]), .qw(s_axis_tdata[63:48]), .m(r1));
    erj_quat u_dq (.clk(clk), .en(adv),
        .qx(s_axis_tdata[79:64]), .qy(s_axis_tdata[95:80]),
        .qz(s_axis_tdata[111:96]), .qw(s_axis_tdata[127:112]), .m(rt1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_1_reg <= p1_in;
            p2_1_reg <= p2_in;
        end
    end

    // Stage 2: v = R p2 and a = p1 x t.
    vec3_t t1, c0_1, c1_1;
    vec3_t v2_reg, v2_next, a2;
    vec3_t p1_2_reg, p2_2_reg, t2_reg, c0_2_reg, c1_2_reg;
    mat3_t r2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t1[i] = rt1[i][2];
            c0_1[i] = rt1[i][0];
            c1_1[i] = rt1[i][1];
            v2_next[i] = sat32(67'(mulq(r1[i][0], p2_1_reg[0]))
                + 67'(mulq(r1[i][1], p2_1_reg[1])) + 67'(mulq(r1[i][2], p2_1_reg[2])));
        end
    end

    erj_cross u_a (.clk(clk), .en(adv), .a(p1_1_reg), .b(t1), .o(a2));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v2_reg <= v2_next;
            p1_2_reg <= p1_1_reg;
            p2_2_reg <= p2_1_reg;
            t2_reg <= t1;
            c0_2_reg <= c0_1;
            c1_2_reg <= c1_1;
            r2_reg <= r1;
        end
    end

    // Stage 3: c = t x v, b = a^T R, d = v x p1.
    vec3_t c3, d3, b3_reg, b3_next;
    vec3_t p1_3_reg, p2_3_reg, c0_3_reg, c1_3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            b3_next[i] = sat32(67'(mulq(a2[0], r2_reg[0][i]))
                + 67'(mulq(a2[1], r2_reg[1][i])) + 67'(mulq(a2[2], r2_reg[2][i])));
    end

    erj_cross u_c (.clk(clk), .en(adv), .a(t2_reg), .b(v2_reg), .o(c3));
    erj_cross u_d (.clk(clk), .en(adv), .a(v2_reg), .b(p1_2_reg), .o(d3));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_reg <= b3_next;
            p1_3_reg <= p1_2_reg;
            p2_3_reg <= p2_2_reg;
            c0_3_reg <= c0_2_reg;
            c1_3_reg <= c1_2_reg;
        end
    end

    // Stage 4: jq = p2 x b; register the dot-product terms.
    vec3_t jq4;
    logic signed [40:0] tr_reg [3];
    logic signed [40:0] ta_reg [3];
    logic signed [40:0] tb_reg [3];

    erj_cross u_j (.clk(clk), .en(adv), .a(p2_3_reg), .b(b3_reg), .o(jq4));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tr_reg[i] <= mulq(p1_3_reg[i], c3[i]);
                ta_reg[i] <= mulq(d3[i], c1_3_reg[i]);
                tb_reg[i] <= mulq(d3[i], c0_3_reg[i]);
            end
        end
    end

    // Stage 5: sum the terms and saturate.
    word_t res5_reg, da5_reg, db5_reg;
    vec3_t jq5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res5_reg <= sat32(67'(tr_reg[0]) + 67'(tr_reg[1]) + 67'(tr_reg[2]));
            da5_reg <= sat32(-(67'(ta_reg[0]) + 67'(ta_reg[1]) + 67'(ta_reg[2])));
            db5_reg <= sat32(67'(tb_reg[0]) + 67'(tb_reg[1]) + 67'(tb_reg[2]));
            jq5_reg <= jq4;
        end
    end

    // Stage 6: output register; hold while the receiver stalls.
    logic [191:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {db5_reg, da5_reg, jq5_reg[2], jq5_reg[1], jq5_reg[0], res5_reg};
    end

    assign m_axis_tdata = out_reg;
endmodule

// ===== hdl/erj_quat.sv =====
// Quaternion to rotation matrix conversion, one registered stage.
module erj_quat
(
    input  logic             clk,
    input  logic             en,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    input  logic signed [15:0] qz,
    input  logic signed [15:0] qw,
    output erj_pkg::mat3_t   m
);
    import erj_pkg::*;

    logic signed [33:0] e [3][3];
    logic signed [33:0] one;
    mat3_t m_reg;
    mat3_t m_next;

    always_comb
    begin
        logic signed [33:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic signed [34:0] r;
        xx = qx * qx; yy = qy * qy; zz = qz * qz;
        xy = qx * qy; xz = qx * qz; yz = qy * qz;
        wx = qw * qx; wy = qw * qy; wz = qw * qz;
        one = 34'sd134217728;
        e[0][0] = one - (yy + zz);
        e[0][1] = xy - wz;
        e[0][2] = xz + wy;
        e[1][0] = xy + wz;
        e[1][1] = one - (xx + zz);
        e[1][2] = yz - wx;
        e[2][0] = xz - wy;
        e[2][1] = yz + wx;
        e[2][2] = one - (xx + yy);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r = ($signed({e[i][j][33], e[i][j]}) + 35'sd4) >>> 3;
                m_next[i][j] = sat32(67'(r));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_reg <= m_next;
    end

    assign m = m_reg;
endmodule

// ===== hdl/erj_cross.sv =====
// Registered cross product of two Q7.24 vectors.
module erj_cross
(
    input  logic          clk,
    input  logic          en,
    input  erj_pkg::vec3_t a,
    input  erj_pkg::vec3_t b,
    output erj_pkg::vec3_t o
);
    import erj_pkg::*;

    vec3_t o_reg;
    vec3_t o_next;

    always_comb
    begin
        o_next[0] = sat32(67'(mulq(a[1], b[2])) - 67'(mulq(a[2], b[1])));
        o_next[1] = sat32(67'(mulq(a[2], b[0])) - 67'(mulq(a[0], b[2])));
        o_next[2] = sat32(67'(mulq(a[0], b[1])) - 67'(mulq(a[1], b[0])));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            o_reg <= o_next;
    end

    assign o = o_reg;
endmodule
